[src/heartbeat_link_supervisor_macros.svh]
// Assertion macros shared by the heartbeat link supervisor RTL.
`ifndef HEARTBEAT_LINK_SUPERVISOR_MACROS_SVH
`define HEARTBEAT_LINK_SUPERVISOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HLS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("heartbeat link supervisor: same-cycle property violated");

// Next-cycle implication, disabled while reset is asserted.
`define HLS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("heartbeat link supervisor: next-cycle property violated");

`endif

[src/hls_pkg.sv]
// Types, codes and defaults shared by the heartbeat link supervisor.
`default_nettype none

package hls_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int CFG_W = 16;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEARTBEAT_PERIOD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINK_RETRY_PERIOD = 2'd2;

	localparam logic [CFG_W-1:0] TIMEOUT_LIMIT_RST = 16'd300;
	localparam logic [CFG_W-1:0] HEARTBEAT_PERIOD_RST = 16'd100;
	localparam logic [CFG_W-1:0] LINK_RETRY_PERIOD_RST = 16'd100;

	localparam logic REQ_TICK = 1'b0;
	localparam logic REQ_MSG = 1'b1;

	localparam logic [7:0] FUNC_COMMAND = 8'h01;
	localparam logic [7:0] FUNC_HEARTBEAT = 8'h02;
	localparam logic [7:0] CMD_LINK = 8'h06;

	typedef enum logic [1:0] {
		TX_NONE = 2'd0,
		TX_HEART = 2'd1,
		TX_LINK_REQ = 2'd2,
		TX_LINK_RSP = 2'd3
	} tx_action_t;

	typedef struct packed {
		logic req_type;
		logic [7:0] func_code;
		logic [7:0] cmd_code;
	} req_t;

	typedef struct packed {
		tx_action_t tx_action;
		logic is_linked;
		logic heard_peer;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] timeout_limit;
		logic [CFG_W-1:0] heartbeat_period;
		logic [CFG_W-1:0] link_retry_period;
	} cfg_t;

endpackage

`default_nettype wire

[src/hls_cfg_regs.sv]
// Configuration register file of the heartbeat link supervisor.
`default_nettype none

module hls_cfg_regs
	import hls_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	output cfg_t cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_limit <= TIMEOUT_LIMIT_RST;
			cfg_q.heartbeat_period <= HEARTBEAT_PERIOD_RST;
			cfg_q.link_retry_period <= LINK_RETRY_PERIOD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit <= cfg_data;
				CFG_HEARTBEAT_PERIOD: cfg_q.heartbeat_period <= cfg_data;
				CFG_LINK_RETRY_PERIOD: cfg_q.link_retry_period <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[src/hls_link_state.sv]
// Link flags, idle/beat/retry counters and the per-item update logic.
`default_nettype none

`include "heartbeat_link_supervisor_macros.svh"

module hls_link_state
	import hls_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic step_en,
	input wire req_t req,
	input wire cfg_t cfg,
	output rsp_t rsp
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	logic seen_q;
	logic link_q;
	logic [COUNT_WIDTH-1:0] idle_q;
	logic [COUNT_WIDTH-1:0] beat_q;
	logic [COUNT_WIDTH-1:0] retry_q;

	logic seen_d;
	logic link_d;
	logic [COUNT_WIDTH-1:0] idle_d;
	logic [COUNT_WIDTH-1:0] beat_d;
	logic [COUNT_WIDTH-1:0] retry_d;
	tx_action_t act;

	logic [COUNT_WIDTH-1:0] idle_inc;
	logic [COUNT_WIDTH-1:0] beat_inc;
	logic [COUNT_WIDTH-1:0] retry_inc;
	logic idle_over;
	logic beat_over;
	logic retry_over;

	assign idle_inc = (idle_q == COUNT_MAX) ? idle_q : idle_q + 1'b1;
	assign beat_inc = (beat_q == COUNT_MAX) ? beat_q : beat_q + 1'b1;
	assign retry_inc = (retry_q == COUNT_MAX) ? retry_q : retry_q + 1'b1;

	assign idle_over = CMP_W'(idle_inc) > CMP_W'(cfg.timeout_limit);
	assign beat_over = CMP_W'(beat_inc) > CMP_W'(cfg.heartbeat_period);
	assign retry_over = CMP_W'(retry_inc) > CMP_W'(cfg.link_retry_period);

	always_comb begin
		seen_d = seen_q;
		link_d = link_q;
		idle_d = idle_q;
		beat_d = beat_q;
		retry_d = retry_q;
		act = TX_NONE;
		if (req.req_type == REQ_MSG) begin
			if (req.func_code == FUNC_COMMAND) begin
				idle_d = '0;
				if (req.cmd_code == CMD_LINK && seen_q) begin
					link_d = 1'b1;
					act = TX_LINK_RSP;
				end
			end else if (req.func_code == FUNC_HEARTBEAT) begin
				seen_d = 1'b1;
				idle_d = '0;
			end
		end else if (seen_q) begin
			priority if (idle_over) begin
				seen_d = 1'b0;
				link_d = 1'b0;
				idle_d = '0;
				beat_d = '0;
				retry_d = '0;
			end else if (link_q) begin
				idle_d = idle_inc;
				beat_d = beat_over ? '0 : beat_inc;
				act = beat_over ? TX_HEART : TX_NONE;
			end else begin
				idle_d = idle_inc;
				retry_d = retry_over ? '0 : retry_inc;
				act = retry_over ? TX_LINK_REQ : TX_NONE;
			end
		end
	end

	assign rsp.tx_action = act;
	assign rsp.is_linked = link_d;
	assign rsp.heard_peer = seen_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			link_q <= 1'b0;
			idle_q <= '0;
			beat_q <= '0;
			retry_q <= '0;
		end else if (step_en) begin
			seen_q <= seen_d;
			link_q <= link_d;
			idle_q <= idle_d;
			beat_q <= beat_d;
			retry_q <= retry_d;
		end
	end

	`HLS_ASSERT_NOW(a_link_needs_seen, clk, arst_n, link_q, seen_q)
	`HLS_ASSERT_NEXT(a_tick_unheard_idle, clk, arst_n,
		step_en && req.req_type == REQ_TICK && !seen_q,
		$stable({seen_q, link_q, idle_q, beat_q, retry_q}))
	`HLS_ASSERT_NEXT(a_heartbeat_marks_seen, clk, arst_n,
		step_en && req.req_type == REQ_MSG && req.func_code == FUNC_HEARTBEAT,
		seen_q && idle_q == '0)

endmodule

`default_nettype wire

[src/heartbeat_link_supervisor.sv]
// Top level of the heartbeat link supervisor: channel registers and wiring.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one item per timer tick or per
//     received message header (req_type, func_code, cmd_code).
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//     input item: tx_action plus the link and heard flags after the item.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): writes the timeout
//     limit, heartbeat period and link retry period; always ready, write only
//     while no item is in flight. Indexes beyond the list are dropped.
//   Path: an accepted item passes the input register, then the result
//     register; while out_ready is low it may wait in the input register.
//   Throughput: one item per cycle while out_ready stays high; the state
//     update is combinational between the input and result registers.
//   Reset: arst_n clears flags, counters and the valid bits of both
//     registers; the config registers return to 300 / 100 / 100.
//   Stall: while out_ready is low the result holds, the input register
//     holds one more item, then in_ready drops.
`default_nettype none

`include "heartbeat_link_supervisor_macros.svh"

module heartbeat_link_supervisor
	import hls_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output rsp_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_INDEX_W-1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);

	logic valid_s1;
	req_t req_s1;
	logic out_valid_q;
	rsp_t out_data_q;
	logic advance;
	logic step_en;
	cfg_t cfg;
	rsp_t rsp_next;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step_en = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	hls_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	hls_link_state #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_state (
		.clk(clk),
		.arst_n(arst_n),
		.step_en(step_en),
		.req(req_s1),
		.cfg(cfg),
		.rsp(rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
		if (step_en) begin
			out_data_q <= rsp_next;
		end
	end

	`HLS_ASSERT_NOW(a_rsp_linked, clk, arst_n,
		out_valid_q && (out_data_q.tx_action == TX_LINK_RSP
			|| out_data_q.tx_action == TX_HEART),
		out_data_q.is_linked)
	`HLS_ASSERT_NOW(a_req_unlinked, clk, arst_n,
		out_valid_q && out_data_q.tx_action == TX_LINK_REQ,
		out_data_q.heard_peer && !out_data_q.is_linked)
	`HLS_ASSERT_NEXT(a_step_fills_out, clk, arst_n, step_en, out_valid_q)

endmodule

`default_nettype wire
